// ===== sv/css_pkg.sv =====
package css_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int DIM_RESET = 1024;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_FRAME_WIDTH  = cfg_index_t'(0);
  localparam cfg_index_t REG_FRAME_HEIGHT = cfg_index_t'(1);

endpackage

// ===== sv/css_sample_if.sv =====
interface css_sample_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== sv/css_result_if.sv =====
interface css_result_if #(
  parameter int SAMPLE_BITS = 24,
  parameter int ROW_BITS    = 10,
  parameter int COL_BITS    = 10
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] smoothed;
  logic [ROW_BITS-1:0]           out_row;
  logic [COL_BITS-1:0]           out_column;
  logic                          last_of_run;
  logic                          end_of_frame;

  modport source (
    output valid, output smoothed, output out_row, output out_column,
    output last_of_run, output end_of_frame, input ready
  );
  modport sink (
    input valid, input smoothed, input out_row, input out_column,
    input last_of_run, input end_of_frame, output ready
  );
endinterface

// ===== sv/css_cfg_if.sv =====
interface css_cfg_if import css_pkg::*; #(
  parameter int DATA_BITS = 11
);
  logic                 valid;
  logic                 ready;
  cfg_index_t           index;
  logic [DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/cross_stencil_smoother.sv =====
// Channel   Modport  Payload                                              Request
// cfg       sink     index, data (frame_width = 0, frame_height = 1)     one register write
// samples   sink     sample                                               one raster sample
// results   source   smoothed, out_row, out_column, last_of_run,          one pixel result
//                    end_of_frame
//
// One sample per cycle while the last stage does not wait; a sample passes stages s1 to s4 and the
// result register before its first result. Last-row samples yield two results each, so the single
// result register paces that row: a new sample enters only as the previous one's second result is emitted.
// Line stores need no clearing after reset; samples are taken from the first cycle.
// A stalled result holds the pipeline; ready drops only while the last stage waits or reset is asserted.
module cross_stencil_smoother import css_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input logic          clk,
  input logic          rst,
  css_cfg_if.sink      cfg,
  css_sample_if.sink   samples,
  css_result_if.source results
);

  localparam int SB = SAMPLE_BITS;
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DWW = $clog2(MAX_WIDTH + 1);
  localparam int DWH = $clog2(MAX_HEIGHT + 1);
  localparam int DW = (DWW > DWH) ? DWW : DWH;
  localparam int SW = SB + 3;
  localparam int MW = SB + 3;
  localparam int PW = 2 * SB + 5;
  localparam int W_RESET = (MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET;
  localparam int H_RESET = (MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << (SB + 4)) + 64'd2) / 64'd3);
  localparam logic [SW-1:0] OFFSET = SW'(64'd3 * (64'd1 << SB) + 64'd3);
  localparam logic [SB-1:0] SIGN_BIT = {1'b1, {(SB-1){1'b0}}};
  localparam logic [DW-1:0] MAXW_D = DW'(MAX_WIDTH);
  localparam logic [DW-1:0] MAXH_D = DW'(MAX_HEIGHT);

  typedef struct packed {
    logic signed [SB-1:0] x;
    logic signed [SB-1:0] centre;
    logic [RW-1:0]        row;
    logic [CW-1:0]        col;
    logic                 need_a;
    logic                 need_b;
    logic                 border;
    logic                 eof;
  } meta_t;

  logic [CW-1:0] col_last;
  logic [RW-1:0] row_last;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [DW-1:0] w_clamp;
  logic [DW-1:0] h_clamp;

  logic signed [SB-1:0] prev_mem [MAX_WIDTH];
  logic signed [SB-1:0] older_mem [MAX_WIDTH];
  logic signed [SB-1:0] q_prev;
  logic signed [SB-1:0] q_older;
  logic signed [SB-1:0] cen_reg;
  logic signed [SB-1:0] left_reg;
  logic [CW-1:0]        raddr;

  logic                 s1_valid, s2_valid, s3_valid, s4_valid;
  meta_t                s1_meta, s2_meta, s3_meta, s4_meta;
  logic signed [SW-1:0] s2_p1, s2_p2;
  logic signed [SW-1:0] p1_next, p2_next;
  logic [SW-1:0]        s3_t, t_next;
  logic [PW-1:0]        s4_prod, prod_next;
  logic signed [SB-1:0] val_a;

  logic slot_free, emit_a, emit_b, s4_done, adv, accept;
  meta_t s1_next;

  logic                 out_valid;
  logic signed [SB-1:0] out_smoothed;
  logic [RW-1:0]        out_row_reg;
  logic [CW-1:0]        out_col_reg;
  logic                 out_last;
  logic                 out_eof;

  // register writes
  assign cfg.ready = !rst;

  always_comb begin
    if (cfg.data == '0) begin
      w_clamp = DW'(1);
    end else if (cfg.data > MAXW_D) begin
      w_clamp = MAXW_D;
    end else begin
      w_clamp = cfg.data;
    end
    if (cfg.data == '0) begin
      h_clamp = DW'(1);
    end else if (cfg.data > MAXH_D) begin
      h_clamp = MAXH_D;
    end else begin
      h_clamp = cfg.data;
    end
  end

  // pipeline control
  assign slot_free = !out_valid || results.ready;
  assign emit_a = s4_valid && s4_meta.need_a && slot_free;
  assign emit_b = s4_valid && !s4_meta.need_a && s4_meta.need_b && slot_free;
  assign s4_done = s4_valid && ((!s4_meta.need_a && !s4_meta.need_b) ||
                                (slot_free && !(s4_meta.need_a && s4_meta.need_b)));
  assign adv = !s4_valid || s4_done;
  assign samples.ready = adv && !rst;
  assign accept = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_last <= CW'(W_RESET - 1);
      row_last <= RW'(H_RESET - 1);
      col <= '0;
      row <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FRAME_WIDTH: begin
          col_last <= CW'(w_clamp - DW'(1));
          col <= '0;
          row <= '0;
        end
        REG_FRAME_HEIGHT: begin
          row_last <= RW'(h_clamp - DW'(1));
          col <= '0;
          row <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      if (col == col_last) begin
        col <= '0;
        row <= (row == row_last) ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // line stores; prev read runs one column ahead
  assign raddr = (col == col_last) ? '0 : col + CW'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_mem[col] <= samples.sample;
      older_mem[col] <= q_prev;
      q_older <= older_mem[col];
      q_prev <= (raddr == col) ? samples.sample : prev_mem[raddr];
      cen_reg <= q_prev;
      left_reg <= cen_reg;
    end
  end

  always_comb begin
    s1_next.x = samples.sample;
    s1_next.centre = q_prev;
    s1_next.row = row;
    s1_next.col = col;
    s1_next.need_a = (row != '0);
    s1_next.need_b = (row == row_last);
    s1_next.border = (row == RW'(1)) || (col == '0) || (col == col_last);
    s1_next.eof = (row == row_last) && (col == col_last);
  end

  assign p1_next = (SW'(s1_meta.centre) <<< 1) + SW'(left_reg) + SW'(q_prev);
  assign p2_next = SW'(q_older) + SW'(s1_meta.x);
  assign t_next = $unsigned(s2_p1 + s2_p2) + OFFSET;
  assign prod_next = PW'(s3_t[SW-1:1]) * PW'(RECIP);
  assign val_a = s4_meta.border ? s4_meta.centre :
                 $signed(s4_prod[SB+4 +: SB] ^ SIGN_BIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (accept) begin
        s1_meta <= s1_next;
      end
      s2_meta <= s1_meta;
      s2_p1 <= p1_next;
      s2_p2 <= p2_next;
      s3_meta <= s2_meta;
      s3_t <= t_next;
      s4_meta <= s3_meta;
      s4_prod <= prod_next;
    end else if (emit_a) begin
      s4_meta.need_a <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_a || emit_b) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_a) begin
      out_smoothed <= val_a;
      out_row_reg <= s4_meta.row - RW'(1);
      out_col_reg <= s4_meta.col;
      out_last <= !s4_meta.need_b;
      out_eof <= 1'b0;
    end else if (emit_b) begin
      out_smoothed <= s4_meta.x;
      out_row_reg <= s4_meta.row;
      out_col_reg <= s4_meta.col;
      out_last <= 1'b1;
      out_eof <= s4_meta.eof;
    end
  end

  assign results.valid = out_valid;
  assign results.smoothed = out_smoothed;
  assign results.out_row = out_row_reg;
  assign results.out_column = out_col_reg;
  assign results.last_of_run = out_last;
  assign results.end_of_frame = out_eof;

endmodule
